// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SEGCULL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that must also hold while reset is asserted.
`define SEGCULL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/segcull_pkg.sv =====
package segcull_pkg;

  // Coordinate and difference widths.
  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  // Signed product of two differences, and the unsigned width of a square.
  localparam int PROD1_W   = 2 * DIFF_W;
  localparam int SQ_W      = PROD1_W - 1;
  // Sums of three squares, and the signed dot product.
  localparam int SUM_W     = SQ_W + 2;
  localparam int DOT_W     = PROD1_W + 2;

  // Range register and the doubled squared range.
  localparam int RANGE_W   = 24;
  localparam int LIM_W     = 2 * RANGE_W + 1;
  localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(10240);

  // Wide multiplier: two limbs per operand, three register stages.
  localparam int MUL_W     = SUM_W;
  localparam int LIMB_W    = 34;
  localparam int HI_W      = MUL_W - LIMB_W;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int CMP_W     = PROD_W + 1;
  localparam int MUL_LAT   = 3;

  // Squared segment lengths up to this value count as degenerate.
  localparam int DEGEN_MAX_SQ = 65;

  // Configuration port.
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POSE_X,
    REG_POSE_Y,
    REG_POSE_Z,
    REG_RANGE
  } cfg_reg_e;

  // One segment as it travels with its request.
  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic                      last_in;
  } seg_t;

  // Geometry front end to decision stage.
  typedef struct packed {
    logic                    valid;
    logic [SUM_W-1:0]        ff;
    logic [SUM_W-1:0]        len;
    logic [SUM_W-1:0]        ee;
    logic signed [DOT_W-1:0] d;
    logic [LIM_W-1:0]        lim;
    seg_t                    seg;
  } geom_t;

  // Finished result.
  typedef struct packed {
    logic keep;
    seg_t seg;
  } res_t;

endpackage

// ===== design/segcull_ifs.sv =====
// Segment request channel.
interface segcull_in_if import segcull_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] start_z;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic signed [COORD_W-1:0] end_z;
  logic                      last_in;

  modport source (
    output valid, start_x, start_y, start_z, end_x, end_y, end_z, last_in,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, start_z, end_x, end_y, end_z, last_in,
    output ready
  );
endinterface

// Cull result channel.
interface segcull_out_if import segcull_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      keep;
  logic signed [COORD_W-1:0] out_start_x;
  logic signed [COORD_W-1:0] out_start_y;
  logic signed [COORD_W-1:0] out_start_z;
  logic signed [COORD_W-1:0] out_end_x;
  logic signed [COORD_W-1:0] out_end_y;
  logic signed [COORD_W-1:0] out_end_z;
  logic                      last_out;

  modport source (
    output valid, keep, out_start_x, out_start_y, out_start_z,
           out_end_x, out_end_y, out_end_z, last_out,
    input  ready
  );
  modport sink (
    input  valid, keep, out_start_x, out_start_y, out_start_z,
           out_end_x, out_end_y, out_end_z, last_out,
    output ready
  );
endinterface

// ===== design/segcull_geom.sv =====
module segcull_geom import segcull_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  seg_t                      seg_i,
  input  logic signed [COORD_W-1:0] pose_x_i,
  input  logic signed [COORD_W-1:0] pose_y_i,
  input  logic signed [COORD_W-1:0] pose_z_i,
  input  logic [RANGE_W-1:0]        range_i,
  output geom_t                     geom_o
);

  logic signed [COORD_W-1:0] st   [3];
  logic signed [COORD_W-1:0] ep   [3];
  logic signed [COORD_W-1:0] pose [3];

  logic signed [DIFF_W-1:0]  f_d [3];
  logic signed [DIFF_W-1:0]  t_d [3];
  logic signed [DIFF_W-1:0]  e_d [3];
  logic [LIM_W-2:0]          r_sq;

  logic                      s1_valid_q;
  seg_t                      s1_seg_q;
  logic signed [DIFF_W-1:0]  s1_f_q [3];
  logic signed [DIFF_W-1:0]  s1_t_q [3];
  logic signed [DIFF_W-1:0]  s1_e_q [3];
  logic [LIM_W-1:0]          s1_lim_q;

  logic signed [PROD1_W-1:0] ffp [3];
  logic signed [PROD1_W-1:0] ttp [3];
  logic signed [PROD1_W-1:0] eep [3];
  logic signed [PROD1_W-1:0] ftp [3];

  logic                      s2_valid_q;
  seg_t                      s2_seg_q;
  logic [SQ_W-1:0]           s2_ff_q [3];
  logic [SQ_W-1:0]           s2_tt_q [3];
  logic [SQ_W-1:0]           s2_ee_q [3];
  logic signed [PROD1_W-1:0] s2_ft_q [3];
  logic [LIM_W-1:0]          s2_lim_q;

  logic [SUM_W-1:0]          ff_d;
  logic [SUM_W-1:0]          len_d;
  logic [SUM_W-1:0]          ee_d;
  logic signed [DOT_W-1:0]   d_d;

  logic                      s3_valid_q;
  seg_t                      s3_seg_q;
  logic [SUM_W-1:0]          s3_ff_q;
  logic [SUM_W-1:0]          s3_len_q;
  logic [SUM_W-1:0]          s3_ee_q;
  logic signed [DOT_W-1:0]   s3_d_q;
  logic [LIM_W-1:0]          s3_lim_q;

  assign st[0]   = seg_i.start_x;
  assign st[1]   = seg_i.start_y;
  assign st[2]   = seg_i.start_z;
  assign ep[0]   = seg_i.end_x;
  assign ep[1]   = seg_i.end_y;
  assign ep[2]   = seg_i.end_z;
  assign pose[0] = pose_x_i;
  assign pose[1] = pose_y_i;
  assign pose[2] = pose_z_i;

  // Stage one: offsets from the pose, segment direction and squared range.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_d[i] = DIFF_W'(st[i]) - DIFF_W'(pose[i]);
      e_d[i] = DIFF_W'(ep[i]) - DIFF_W'(pose[i]);
      t_d[i] = DIFF_W'(ep[i]) - DIFF_W'(st[i]);
    end
  end

  assign r_sq = (LIM_W-1)'(range_i) * (LIM_W-1)'(range_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_seg_q <= seg_i;
      s1_f_q   <= f_d;
      s1_t_q   <= t_d;
      s1_e_q   <= e_d;
      s1_lim_q <= {r_sq, 1'b0};
    end
  end

  // Stage two: one signed multiplier per component and term.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ffp[i] = PROD1_W'(s1_f_q[i]) * PROD1_W'(s1_f_q[i]);
      ttp[i] = PROD1_W'(s1_t_q[i]) * PROD1_W'(s1_t_q[i]);
      eep[i] = PROD1_W'(s1_e_q[i]) * PROD1_W'(s1_e_q[i]);
      ftp[i] = PROD1_W'(s1_f_q[i]) * PROD1_W'(s1_t_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_seg_q <= s1_seg_q;
      s2_lim_q <= s1_lim_q;
      for (int i = 0; i < 3; i++) begin
        s2_ff_q[i] <= ffp[i][SQ_W-1:0];
        s2_tt_q[i] <= ttp[i][SQ_W-1:0];
        s2_ee_q[i] <= eep[i][SQ_W-1:0];
        s2_ft_q[i] <= ftp[i];
      end
    end
  end

  // Stage three: squared lengths and the dot product.
  always_comb begin
    ff_d  = SUM_W'(s2_ff_q[0]) + SUM_W'(s2_ff_q[1]) + SUM_W'(s2_ff_q[2]);
    len_d = SUM_W'(s2_tt_q[0]) + SUM_W'(s2_tt_q[1]) + SUM_W'(s2_tt_q[2]);
    ee_d  = SUM_W'(s2_ee_q[0]) + SUM_W'(s2_ee_q[1]) + SUM_W'(s2_ee_q[2]);
    d_d   = DOT_W'(s2_ft_q[0]) + DOT_W'(s2_ft_q[1]) + DOT_W'(s2_ft_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_seg_q <= s2_seg_q;
      s3_lim_q <= s2_lim_q;
      s3_ff_q  <= ff_d;
      s3_len_q <= len_d;
      s3_ee_q  <= ee_d;
      s3_d_q   <= d_d;
    end
  end

  always_comb begin
    geom_o.valid = s3_valid_q;
    geom_o.ff    = s3_ff_q;
    geom_o.len   = s3_len_q;
    geom_o.ee    = s3_ee_q;
    geom_o.d     = s3_d_q;
    geom_o.lim   = s3_lim_q;
    geom_o.seg   = s3_seg_q;
  end

endmodule

// ===== design/segcull_wmul.sv =====
module segcull_wmul import segcull_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [MUL_W-1:0]  a_i,
  input  logic [MUL_W-1:0]  b_i,
  output logic [PROD_W-1:0] p_o
);

  logic [LIMB_W-1:0]        a_lo;
  logic [LIMB_W-1:0]        b_lo;
  logic [HI_W-1:0]          a_hi;
  logic [HI_W-1:0]          b_hi;

  logic [2*LIMB_W-1:0]      pp_ll_q;
  logic [LIMB_W+HI_W-1:0]   pp_lh_q;
  logic [LIMB_W+HI_W-1:0]   pp_hl_q;
  logic [2*HI_W-1:0]        pp_hh_q;

  logic [LIMB_W+HI_W:0]     mid_q;
  logic [2*LIMB_W-1:0]      ll2_q;
  logic [2*HI_W-1:0]        hh2_q;

  logic [PROD_W-1:0]        p_q;

  assign a_lo = a_i[LIMB_W-1:0];
  assign a_hi = a_i[MUL_W-1:LIMB_W];
  assign b_lo = b_i[LIMB_W-1:0];
  assign b_hi = b_i[MUL_W-1:LIMB_W];

  // First stage: four limb products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_ll_q <= (2*LIMB_W)'(a_lo) * (2*LIMB_W)'(b_lo);
      pp_lh_q <= (LIMB_W+HI_W)'(a_lo) * (LIMB_W+HI_W)'(b_hi);
      pp_hl_q <= (LIMB_W+HI_W)'(a_hi) * (LIMB_W+HI_W)'(b_lo);
      pp_hh_q <= (2*HI_W)'(a_hi) * (2*HI_W)'(b_hi);
    end
  end

  // Second stage: merge the two cross products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= (LIMB_W+HI_W+1)'(pp_lh_q) + (LIMB_W+HI_W+1)'(pp_hl_q);
      ll2_q <= pp_ll_q;
      hh2_q <= pp_hh_q;
    end
  end

  // Third stage: outer products sit side by side, the middle term is added in.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= {hh2_q, ll2_q} + (PROD_W'(mid_q) << LIMB_W);
    end
  end

  assign p_o = p_q;

endmodule

// ===== design/segcull_skid.sv =====
`include "assert_macros.svh"

module segcull_skid import segcull_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  res_t data_i,
  output logic ready_o,
  output logic valid_o,
  output res_t data_o,
  input  logic ready_i
);

  logic ov_q;
  logic sv_q;
  res_t od_q;
  res_t sd_q;
  logic push;
  logic out_fire;

  assign ready_o  = !sv_q;
  assign push     = valid_i && !sv_q;
  assign out_fire = ov_q && ready_i;

  // Output register with one spare entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (sv_q) begin
      if (out_fire) begin
        sv_q <= 1'b0;
      end
    end else if (push) begin
      if (ov_q && !out_fire) begin
        sv_q <= 1'b1;
      end
      ov_q <= 1'b1;
    end else if (out_fire) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      if (out_fire) begin
        od_q <= sd_q;
      end
    end else if (push) begin
      if (!ov_q || out_fire) begin
        od_q <= data_i;
      end else begin
        sd_q <= data_i;
      end
    end
  end

  assign valid_o = ov_q;
  assign data_o  = od_q;

  `SEGCULL_ASSERT_RST(a_skid_behind_out, sv_q |-> ov_q, "spare entry held while output register is empty")
  `SEGCULL_ASSERT(a_stalled_push, push && ov_q && !ready_i |=> sv_q && ov_q, "stalled request not parked in spare entry")

endmodule

// ===== design/segment_range_cull.sv =====
// An accepted request passes geometry stages one to three, stage four and the multiplier stages to the output register.
// Throughput: one request per cycle while the spare entry is empty; every stage is registered and fully pipelined.
// The longest path is one 34 x 34 limb product of the wide multipliers.
// Back pressure parks one result in a spare entry and then holds the whole pipeline.
// Reset clears all valid bits, sets the pose to zero and the range to 10240.
`include "assert_macros.svh"

module segment_range_cull import segcull_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_wdata_i,
  segcull_in_if.sink           seg_i,
  segcull_out_if.source        res_o
);

  typedef struct packed {
    logic interior;
    logic early_keep;
    seg_t seg;
  } side_t;

  logic signed [COORD_W-1:0] pose_x_q;
  logic signed [COORD_W-1:0] pose_y_q;
  logic signed [COORD_W-1:0] pose_z_q;
  logic [RANGE_W-1:0]        range_q;

  logic                      en;
  seg_t                      in_seg;
  geom_t                     geom;

  logic                      degen;
  logic                      d_neg;
  logic signed [DOT_W:0]     dl;
  logic                      end_near;
  logic                      start_in;
  logic                      end_in;
  logic                      interior_d;
  logic                      early_keep_d;

  logic                      s4_valid_q;
  logic                      s4_interior_q;
  logic                      s4_early_q;
  logic [MUL_W-1:0]          s4_ff_q;
  logic [MUL_W-1:0]          s4_len_q;
  logic [MUL_W-1:0]          s4_dm_q;
  logic [MUL_W-1:0]          s4_lim_q;
  seg_t                      s4_seg_q;

  logic [MUL_LAT-1:0]        side_vld_q;
  side_t                     side_q [MUL_LAT];

  logic [PROD_W-1:0]         lhs_p;
  logic [PROD_W-1:0]         d2_p;
  logic [PROD_W-1:0]         limlen_p;
  logic [CMP_W-1:0]          rhs;
  logic                      keep_in;
  res_t                      fin;
  logic                      out_vld;
  res_t                      out_res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_x_q <= '0;
      pose_y_q <= '0;
      pose_z_q <= '0;
      range_q  <= RANGE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_POSE_X: pose_x_q <= cfg_wdata_i;
        REG_POSE_Y: pose_y_q <= cfg_wdata_i;
        REG_POSE_Z: pose_z_q <= cfg_wdata_i;
        REG_RANGE:  range_q  <= cfg_wdata_i[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Request side.
  assign seg_i.ready = en;

  always_comb begin
    in_seg.start_x = seg_i.start_x;
    in_seg.start_y = seg_i.start_y;
    in_seg.start_z = seg_i.start_z;
    in_seg.end_x   = seg_i.end_x;
    in_seg.end_y   = seg_i.end_y;
    in_seg.end_z   = seg_i.end_z;
    in_seg.last_in = seg_i.last_in;
  end

  segcull_geom u_geom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (seg_i.valid),
    .seg_i    (in_seg),
    .pose_x_i (pose_x_q),
    .pose_y_i (pose_y_q),
    .pose_z_i (pose_z_q),
    .range_i  (range_q),
    .geom_o   (geom)
  );

  // Stage four: pick the nearest part of the segment and settle the easy cases.
  always_comb begin
    degen        = geom.len <= SUM_W'(DEGEN_MAX_SQ);
    d_neg        = geom.d[DOT_W-1];
    dl           = (DOT_W+1)'(geom.d) + {2'b00, geom.len};
    end_near     = dl[DOT_W] || (dl == '0);
    start_in     = geom.ff < SUM_W'(geom.lim);
    end_in       = geom.ee < SUM_W'(geom.lim);
    interior_d   = !degen && d_neg && !end_near;
    early_keep_d = (degen || !d_neg) ? start_in : end_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= geom.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_interior_q <= interior_d;
      s4_early_q    <= early_keep_d;
      s4_ff_q       <= geom.ff;
      s4_len_q      <= geom.len;
      s4_dm_q       <= MUL_W'(-geom.d);
      s4_lim_q      <= MUL_W'(geom.lim);
      s4_seg_q      <= geom.seg;
    end
  end

  // Interior case: compare |f|^2 * L against d^2 + 2 R^2 * L.
  segcull_wmul u_mul_ff_len (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (s4_ff_q),
    .b_i   (s4_len_q),
    .p_o   (lhs_p)
  );

  segcull_wmul u_mul_dd (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (s4_dm_q),
    .b_i   (s4_dm_q),
    .p_o   (d2_p)
  );

  segcull_wmul u_mul_lim_len (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (s4_lim_q),
    .b_i   (s4_len_q),
    .p_o   (limlen_p)
  );

  // Side band that keeps step with the multipliers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_vld_q <= '0;
    end else if (en) begin
      side_vld_q <= {side_vld_q[MUL_LAT-2:0], s4_valid_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{interior: s4_interior_q, early_keep: s4_early_q, seg: s4_seg_q};
      for (int i = 1; i < MUL_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Final decision, written into the output register or the spare entry.
  always_comb begin
    rhs      = CMP_W'(d2_p) + CMP_W'(limlen_p);
    keep_in  = CMP_W'(lhs_p) < rhs;
    fin.keep = side_q[MUL_LAT-1].interior ? keep_in : side_q[MUL_LAT-1].early_keep;
    fin.seg  = side_q[MUL_LAT-1].seg;
  end

  segcull_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (side_vld_q[MUL_LAT-1]),
    .data_i  (fin),
    .ready_o (en),
    .valid_o (out_vld),
    .data_o  (out_res),
    .ready_i (res_o.ready)
  );

  // Result side.
  always_comb begin
    res_o.valid       = out_vld;
    res_o.keep        = out_res.keep;
    res_o.out_start_x = out_res.seg.start_x;
    res_o.out_start_y = out_res.seg.start_y;
    res_o.out_start_z = out_res.seg.start_z;
    res_o.out_end_x   = out_res.seg.end_x;
    res_o.out_end_y   = out_res.seg.end_y;
    res_o.out_end_z   = out_res.seg.end_z;
    res_o.last_out    = out_res.seg.last_in;
  end

  `SEGCULL_ASSERT(a_interior_span, s4_valid_q && s4_interior_q |-> (s4_dm_q != '0) && (s4_dm_q < s4_len_q), "interior projection outside the open segment")

endmodule
